// File: src/histogram_auto_stretch_defines.svh
// Assertion macros for the histogram auto-stretch block.
// Used by files that assert; expects clock and reset in scope.
`ifndef HISTOGRAM_AUTO_STRETCH_DEFINES_SVH
`define HISTOGRAM_AUTO_STRETCH_DEFINES_SVH

// check in the same cycle
`define HSA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check in the following cycle
`define HSA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/hsa_pkg.sv
// Shared types and constants for the histogram auto-stretch block.
// No dependencies.
package hsa_pkg;

   localparam int BINS       = 65536;
   localparam int COUNT_BITS = 32;
   localparam int BIN_BITS   = $clog2(BINS);
   localparam int SUM_BITS   = (COUNT_BITS + BIN_BITS > 32) ? COUNT_BITS + BIN_BITS : 33;

   localparam int SAMPLE_BITS = 16;
   localparam int LEVEL_BITS  = 16;
   localparam int PIX_BITS    = 8;
   localparam int STEP_BITS   = $clog2(PIX_BITS);

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [BIN_BITS-1:0]   TOP_BIN   = BIN_BITS'(BINS - 1);
   localparam logic [BIN_BITS-1:0]   TOP_BIN_8 = BIN_BITS'(255);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [PIX_BITS-1:0]   PIX_MAX   = {PIX_BITS{1'b1}};

   localparam logic [1:0] FUNC_COUNT  = 2'd0;
   localparam logic [1:0] FUNC_FINISH = 2'd1;
   localparam logic [1:0] FUNC_MAP    = 2'd2;

   localparam logic KIND_LEVELS = 1'b0;
   localparam logic KIND_PIXEL  = 1'b1;

   localparam logic CSR_IDX_SAMPLE_MODE = 1'b0;
   localparam logic CSR_IDX_WHITE_COUNT = 1'b1;

   typedef struct packed {
      logic                  rd_en;
      logic [BIN_BITS-1:0]   rd_addr;
      logic                  wr_en;
      logic [BIN_BITS-1:0]   wr_addr;
      logic [COUNT_BITS-1:0] wr_data;
   } ram_req_type;

   typedef struct packed {
      logic                   start;
      logic [LEVEL_BITS-1:0]  dividend;
      logic [LEVEL_BITS-1:0]  divisor;
   } div_req_type;

endpackage

// File: src/hsa_ram.sv
// Histogram bin memory: one write port, one registered read port, read-first.
// Depends on hsa_pkg.
module hsa_ram (
   input  logic                          clock,
   input  hsa_pkg::ram_req_type          req,
   output logic [hsa_pkg::COUNT_BITS-1:0] rd_data
);

   logic [hsa_pkg::COUNT_BITS-1:0] mem [hsa_pkg::BINS];
   logic [hsa_pkg::COUNT_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/hsa_div.sv
// Restoring divider, one quotient bit per cycle, for the pixel stretch.
// Expects dividend below divisor; depends on hsa_pkg.
module hsa_div (
   input  logic                         clock,
   input  logic                         reset,
   input  hsa_pkg::div_req_type         div_req,
   output logic                         done,
   output logic [hsa_pkg::PIX_BITS-1:0] quotient
);

   logic [hsa_pkg::LEVEL_BITS-1:0] rem_ff, rem_in, divisor_ff;
   logic [hsa_pkg::PIX_BITS-1:0]   quot_ff, quot_in;
   logic [hsa_pkg::STEP_BITS-1:0]  step_ff;
   logic                           active_ff, done_ff;
   logic [hsa_pkg::LEVEL_BITS:0]   shifted;
   logic                           ge;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      ge      = shifted >= {1'b0, divisor_ff};
      rem_in  = ge ? hsa_pkg::LEVEL_BITS'(shifted - {1'b0, divisor_ff})
                   : shifted[hsa_pkg::LEVEL_BITS-1:0];
      quot_in = {quot_ff[hsa_pkg::PIX_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            rem_ff     <= div_req.dividend;
            divisor_ff <= div_req.divisor;
            quot_ff    <= '0;
            step_ff    <= '0;
            active_ff  <= 1'b1;
         end else if (active_ff) begin
            rem_ff  <= rem_in;
            quot_ff <= quot_in;
            if (step_ff == hsa_pkg::STEP_BITS'(hsa_pkg::PIX_BITS - 1)) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end else begin
               step_ff <= step_ff + 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: src/histogram_auto_stretch.sv
// Histogram auto-levels stretch: top level with control, count pipeline and CSRs.
// Depends on hsa_pkg, hsa_ram, hsa_div and histogram_auto_stretch_defines.svh.
//
// Usage:
//   An item is taken on start while busy is low. func selects count, finish or map.
//   Count: one beat per cycle while busy is low, no result; a read-increment-write
//     pipeline in the bin memory, with forwarding for back-to-back hits on one bin.
//   Finish: sweeps all BINS bins from the top down, reading and clearing each,
//     then gives the levels result. busy stays high for the sweep.
//   Map: clamped samples give a result in the cycle after the beat; otherwise the
//     8-step divider runs and the result is registered once it is done, busy
//     high meanwhile.
//   Results: rsp_valid marks each result for one cycle; the receiver cannot stall.
//   Reset: synchronous; a clearing sweep over all BINS bins zeroes the bin
//     memory while busy is high. CSR writes are taken at any time but during reset.
//   CSRs: sample_mode at 0x0, white_count at 0x4.
`include "histogram_auto_stretch_defines.svh"
module histogram_auto_stretch (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_func,
   input  logic [hsa_pkg::SAMPLE_BITS-1:0]     req_sample,
   output logic                                rsp_valid,
   output logic                                rsp_kind,
   output logic [hsa_pkg::LEVEL_BITS-1:0]      rsp_black_level,
   output logic [hsa_pkg::LEVEL_BITS-1:0]      rsp_white_level,
   output logic [hsa_pkg::PIX_BITS-1:0]        rsp_pixel_out,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [hsa_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [hsa_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [hsa_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready
);

   typedef enum logic [2:0] {ST_IDLE, ST_CLEAR, ST_SCAN, ST_DRAIN, ST_DIVIDE} state_type;

   state_type state_ff;

   logic                              sample_mode_ff;
   logic [31:0]                       white_count_ff;

   logic [hsa_pkg::BIN_BITS-1:0]      addr_ff, sa_ff, sw_ff, sb_ff;
   logic [hsa_pkg::BIN_BITS-1:0]      black_ff, white_ff;
   logic [hsa_pkg::BIN_BITS-1:0]      white_in, black_in;
   logic [hsa_pkg::SUM_BITS-1:0]      sum_ff, sum_in;
   logic                              found_ff, found_in, sv_ff;

   logic                              cv_ff, fwd_v_ff;
   logic [hsa_pkg::BIN_BITS-1:0]      ca_ff, fwd_a_ff;
   logic [hsa_pkg::COUNT_BITS-1:0]    fwd_d_ff, cnt_use, cnt_new;

   logic                              rsp_valid_ff, rsp_kind_ff;
   logic [hsa_pkg::LEVEL_BITS-1:0]    rsp_black_ff, rsp_white_ff;
   logic [hsa_pkg::PIX_BITS-1:0]      rsp_pixel_ff;

   logic                              accept, csr_write;
   logic [hsa_pkg::BIN_BITS-1:0]      top_bin, bin;
   logic [hsa_pkg::SAMPLE_BITS-1:0]   s16;
   logic signed [hsa_pkg::LEVEL_BITS:0] diff, range;
   logic                              map_high, map_low;

   hsa_pkg::ram_req_type              ram_req;
   logic [hsa_pkg::COUNT_BITS-1:0]    rd_data;
   hsa_pkg::div_req_type              div_req;
   logic                              div_done;
   logic [hsa_pkg::PIX_BITS-1:0]      div_quotient;

   hsa_ram u_ram (
      .clock   (clock),
      .req     (ram_req),
      .rd_data (rd_data)
   );

   hsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // csr port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == hsa_pkg::CSR_IDX_WHITE_COUNT) ? white_count_ff
                                                                 : {31'd0, sample_mode_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_mode_ff <= 1'b1;
         white_count_ff <= '0;
      end else if (csr_write) begin
         if (paddr[2] == hsa_pkg::CSR_IDX_SAMPLE_MODE) begin
            sample_mode_ff <= pwdata[0];
         end else begin
            white_count_ff <= pwdata;
         end
      end
   end

   // sample decode
   always_comb begin
      top_bin  = sample_mode_ff ? hsa_pkg::TOP_BIN : hsa_pkg::TOP_BIN_8;
      s16      = sample_mode_ff ? req_sample : {8'h00, req_sample[7:0]};
      bin      = (32'(s16) > 32'(hsa_pkg::BINS - 1)) ? hsa_pkg::TOP_BIN
                                                     : hsa_pkg::BIN_BITS'(s16);
      diff     = $signed({1'b0, s16}) - $signed({1'b0, hsa_pkg::LEVEL_BITS'(black_ff)});
      range    = $signed({1'b0, hsa_pkg::LEVEL_BITS'(white_ff)})
               - $signed({1'b0, hsa_pkg::LEVEL_BITS'(black_ff)});
      map_high = diff >= range;
      map_low  = diff < 0;
   end

   assign div_req.start    = accept && (req_func == hsa_pkg::FUNC_MAP) && !map_high && !map_low;
   assign div_req.dividend = diff[hsa_pkg::LEVEL_BITS-1:0];
   assign div_req.divisor  = range[hsa_pkg::LEVEL_BITS-1:0];

   // count pipeline: forward the bin written in the cycle its re-read was issued
   always_comb begin
      cnt_use = (fwd_v_ff && (fwd_a_ff == ca_ff)) ? fwd_d_ff : rd_data;
      cnt_new = (cnt_use == hsa_pkg::COUNT_MAX) ? cnt_use
                                                : cnt_use + hsa_pkg::COUNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff    <= 1'b0;
         fwd_v_ff <= 1'b0;
      end else begin
         cv_ff    <= accept && (req_func == hsa_pkg::FUNC_COUNT);
         fwd_v_ff <= cv_ff;
      end
      ca_ff    <= bin;
      fwd_a_ff <= ca_ff;
      fwd_d_ff <= cnt_new;
   end

   // memory access
   always_comb begin
      ram_req = '0;
      if (cv_ff) begin
         ram_req.wr_en   = 1'b1;
         ram_req.wr_addr = ca_ff;
         ram_req.wr_data = cnt_new;
      end
      if (accept && (req_func == hsa_pkg::FUNC_COUNT)) begin
         ram_req.rd_en   = 1'b1;
         ram_req.rd_addr = bin;
      end
      if (state_ff == ST_SCAN) begin
         ram_req.rd_en   = 1'b1;
         ram_req.rd_addr = addr_ff;
      end
      if ((state_ff == ST_SCAN) || (state_ff == ST_CLEAR)) begin
         ram_req.wr_en   = 1'b1;
         ram_req.wr_addr = addr_ff;
         ram_req.wr_data = '0;
      end
   end

   // level search over returned bins
   always_comb begin
      sum_in   = sum_ff;
      found_in = found_ff;
      white_in = sw_ff;
      black_in = sb_ff;
      if (sv_ff && (sa_ff <= top_bin)) begin
         if (!found_ff) begin
            sum_in = sum_ff + hsa_pkg::SUM_BITS'(rd_data);
            if (sum_in >= hsa_pkg::SUM_BITS'(white_count_ff)) begin
               found_in = 1'b1;
               white_in = sa_ff;
            end
         end
         if ((rd_data != '0) && (sa_ff < top_bin)) begin
            black_in = sa_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= hsa_pkg::TOP_BIN;
         sv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         black_ff     <= '0;
         white_ff     <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         sv_ff        <= 1'b0;
         if (sv_ff) begin
            sum_ff   <= sum_in;
            found_ff <= found_in;
            sw_ff    <= white_in;
            sb_ff    <= black_in;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_func == hsa_pkg::FUNC_FINISH)) begin
                  state_ff <= ST_SCAN;
                  addr_ff  <= hsa_pkg::TOP_BIN;
                  sum_ff   <= '0;
                  found_ff <= 1'b0;
                  sw_ff    <= '0;
                  sb_ff    <= top_bin;
               end else if (accept && (req_func == hsa_pkg::FUNC_MAP)) begin
                  if (map_high || map_low) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_kind_ff  <= hsa_pkg::KIND_PIXEL;
                     rsp_black_ff <= '0;
                     rsp_white_ff <= '0;
                     rsp_pixel_ff <= map_high ? hsa_pkg::PIX_MAX : '0;
                  end else begin
                     state_ff <= ST_DIVIDE;
                  end
               end
            end
            ST_CLEAR: begin
               if (addr_ff == '0) begin
                  state_ff <= ST_IDLE;
               end else begin
                  addr_ff <= addr_ff - 1'b1;
               end
            end
            ST_SCAN: begin
               sv_ff <= 1'b1;
               sa_ff <= addr_ff;
               if (addr_ff == '0) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  addr_ff <= addr_ff - 1'b1;
               end
            end
            ST_DRAIN: begin
               if (sv_ff) begin
                  black_ff     <= black_in;
                  white_ff     <= white_in;
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= hsa_pkg::KIND_LEVELS;
                  rsp_black_ff <= hsa_pkg::LEVEL_BITS'(black_in);
                  rsp_white_ff <= hsa_pkg::LEVEL_BITS'(white_in);
                  rsp_pixel_ff <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= hsa_pkg::KIND_PIXEL;
                  rsp_black_ff <= '0;
                  rsp_white_ff <= '0;
                  rsp_pixel_ff <= div_quotient;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_black_level = rsp_black_ff;
   assign rsp_white_level = rsp_white_ff;
   assign rsp_pixel_out   = rsp_pixel_ff;

   `HSA_ASSERT_SAME(a_sweep_no_count, (state_ff == ST_SCAN) || (state_ff == ST_CLEAR), !cv_ff, "count write during sweep")
   `HSA_ASSERT_SAME(a_one_reader, 1'b1, !(cv_ff && sv_ff), "count and scan data overlap")
   `HSA_ASSERT_SAME(a_div_owner, div_done, state_ff == ST_DIVIDE, "divider done outside divide")
   `HSA_ASSERT_NEXT(a_levels_out, (state_ff == ST_DRAIN) && sv_ff, rsp_valid_ff && (rsp_kind_ff == hsa_pkg::KIND_LEVELS), "levels result missing")
   `HSA_ASSERT_NEXT(a_pixel_out, div_done, rsp_valid_ff && (rsp_kind_ff == hsa_pkg::KIND_PIXEL), "pixel result missing")

endmodule

// File: sim/histogram_auto_stretch_checker.sv
`timescale 1ns / 100ps
// Scoreboard for histogram_auto_stretch: tracks item, result and CSR beats, keeps its own
// histogram, levels and settings, and compares every result beat field by field.
// Depends on hsa_pkg.
module histogram_auto_stretch_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [1:0]                        req_func,
   input  logic [hsa_pkg::SAMPLE_BITS-1:0]   req_sample,
   input  logic                              rsp_valid,
   input  logic                              rsp_kind,
   input  logic [hsa_pkg::LEVEL_BITS-1:0]    rsp_black_level,
   input  logic [hsa_pkg::LEVEL_BITS-1:0]    rsp_white_level,
   input  logic [hsa_pkg::PIX_BITS-1:0]      rsp_pixel_out,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [hsa_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [hsa_pkg::CSR_DATA_BITS-1:0] pwdata,
   input  logic                              pready,
   output int unsigned                       fail_count,
   output int unsigned                       results_due
);
   import hsa_pkg::*;

   typedef struct packed {
      logic                  kind;
      logic [LEVEL_BITS-1:0] black;
      logic [LEVEL_BITS-1:0] white;
      logic [PIX_BITS-1:0]   pixel;
   } stretch_result_type;

   logic [COUNT_BITS-1:0] bin_count [BINS];
   logic [LEVEL_BITS-1:0] black_level;
   logic [LEVEL_BITS-1:0] white_level;
   logic                  mode_16bit;
   logic [31:0]           white_target;
   stretch_result_type    stretch_due_q [$];
   int unsigned           mismatches = 0;

   initial begin
      fail_count  = 0;
      results_due = 0;
   end

   function automatic logic [BIN_BITS-1:0] bin_of(input logic [SAMPLE_BITS-1:0] s);
      int unsigned b;
      b = mode_16bit ? int'(s) : int'(s[7:0]);
      if (b > BINS - 1) b = BINS - 1;
      return BIN_BITS'(b);
   endfunction

   function automatic void clear_bins();
      for (int i = 0; i < BINS; i++) bin_count[BIN_BITS'(i)] = '0;
   endfunction

   function automatic stretch_result_type scan_levels();
      stretch_result_type  r;
      int unsigned         top;
      int unsigned         w;
      int unsigned         b;
      logic [SUM_BITS-1:0] total;
      top   = mode_16bit ? BINS - 1 : 255;
      w     = top;
      total = SUM_BITS'(bin_count[BIN_BITS'(top)]);
      while (total < SUM_BITS'(white_target) && w > 0) begin
         w     = w - 1;
         total = total + SUM_BITS'(bin_count[BIN_BITS'(w)]);
      end
      b = 0;
      while (b < top && bin_count[BIN_BITS'(b)] == '0) b = b + 1;
      black_level = LEVEL_BITS'(b);
      white_level = LEVEL_BITS'(w);
      clear_bins();
      r.kind  = KIND_LEVELS;
      r.black = black_level;
      r.white = white_level;
      r.pixel = '0;
      return r;
   endfunction

   function automatic logic [PIX_BITS-1:0] stretch_pixel(input logic [SAMPLE_BITS-1:0] s);
      int diff;
      int span;
      diff = (mode_16bit ? int'(s) : int'(s[7:0])) - int'(black_level);
      span = int'(white_level) - int'(black_level);
      if (diff >= span) return PIX_MAX;
      if (diff < 0) return '0;
      return PIX_BITS'((diff * 256) / span);
   endfunction

   task automatic compare_field(input string name, input logic [LEVEL_BITS-1:0] want,
                                input logic [LEVEL_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t checker: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : track
      stretch_result_type  beat;
      logic [BIN_BITS-1:0] idx;
      if (reset) begin
         mode_16bit   = 1'b1;
         white_target = '0;
         black_level  = '0;
         white_level  = '0;
         clear_bins();
         stretch_due_q.delete();
      end else begin
         if (rsp_valid) begin
            if (stretch_due_q.size() == 0) begin
               $display("%0t checker: result beat with none expected, kind %0d", $time,
                        rsp_kind);
               mismatches++;
            end else begin
               beat = stretch_due_q.pop_front();
               compare_field("kind", LEVEL_BITS'(beat.kind), LEVEL_BITS'(rsp_kind));
               compare_field("black_level", beat.black, rsp_black_level);
               compare_field("white_level", beat.white, rsp_white_level);
               compare_field("pixel_out", LEVEL_BITS'(beat.pixel), LEVEL_BITS'(rsp_pixel_out));
            end
         end
         if (start && !busy) begin
            case (req_func)
               FUNC_COUNT: begin
                  idx = bin_of(req_sample);
                  if (bin_count[idx] != COUNT_MAX) bin_count[idx] = bin_count[idx] + 1'b1;
               end
               FUNC_FINISH: begin
                  stretch_due_q.push_back(scan_levels());
               end
               FUNC_MAP: begin
                  beat.kind  = KIND_PIXEL;
                  beat.black = '0;
                  beat.white = '0;
                  beat.pixel = stretch_pixel(req_sample);
                  stretch_due_q.push_back(beat);
               end
               default: ;
            endcase
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_BITS-1:2])
               CSR_IDX_SAMPLE_MODE: mode_16bit   = pwdata[0];
               CSR_IDX_WHITE_COUNT: white_target = pwdata[31:0];
               default: ;
            endcase
         end
      end
      fail_count  <= mismatches;
      results_due <= stretch_due_q.size();
   end

endmodule

// File: sim/histogram_auto_stretch_tb.sv
`timescale 1ns / 100ps
// Testbench top for histogram_auto_stretch: clock, reset, CSR setup and item stimulus,
// plus the idle watchdog and the verdict. Depends on hsa_pkg, the block and the checker.
module histogram_auto_stretch_tb;
   import hsa_pkg::*;

   localparam logic [1:0] FUNC_IGNORED = 2'd3;
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_SAMPLE_MODE =
      CSR_ADDR_BITS'(4 * CSR_IDX_SAMPLE_MODE);
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_WHITE_COUNT =
      CSR_ADDR_BITS'(4 * CSR_IDX_WHITE_COUNT);
   localparam int unsigned IDLE_LIMIT    = 300000;
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned RANDOM_ITEMS  = 1420;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     start      = 1'b0;
   logic [1:0]               req_func   = FUNC_COUNT;
   logic [SAMPLE_BITS-1:0]   req_sample = '0;
   logic                     psel       = 1'b0;
   logic                     penable    = 1'b0;
   logic                     pwrite     = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr      = '0;
   logic [CSR_DATA_BITS-1:0] pwdata     = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;
   logic                     busy;
   logic                     rsp_valid;
   logic                     rsp_kind;
   logic [LEVEL_BITS-1:0]    rsp_black_level;
   logic [LEVEL_BITS-1:0]    rsp_white_level;
   logic [PIX_BITS-1:0]      rsp_pixel_out;
   int unsigned              fail_count;
   int unsigned              results_due;
   int unsigned              idle_cycles = 0;
   int unsigned              gap_max     = 3;
   int unsigned              random_sent = 0;

   always #5 clock = ~clock;

   histogram_auto_stretch DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_black_level (rsp_black_level),
      .rsp_white_level (rsp_white_level),
      .rsp_pixel_out   (rsp_pixel_out),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   histogram_auto_stretch_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_black_level (rsp_black_level),
      .rsp_white_level (rsp_white_level),
      .rsp_pixel_out   (rsp_pixel_out),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .pready          (pready),
      .fail_count      (fail_count),
      .results_due     (results_due)
   );

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (psel && penable)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_item(input logic [1:0] func, input logic [SAMPLE_BITS-1:0] sample);
      int unsigned gap;
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_func   <= func;
      req_sample <= sample;
      do @(posedge clock); while (busy);
   endtask

   // hold off until every result is in, then let the count pipeline settle
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (results_due != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [SAMPLE_BITS-1:0] base,
                                                          input int unsigned spread);
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         2, 3: return SAMPLE_BITS'($urandom);
         default: return base + SAMPLE_BITS'($urandom_range(0, spread));
      endcase
   endfunction

   task automatic run_phase(input int unsigned n_items);
      int unsigned            n_count;
      int unsigned            n_map;
      int unsigned            r;
      logic                   mode;
      logic [31:0]            target;
      logic [SAMPLE_BITS-1:0] base;
      int unsigned            spread;
      drain_results();
      mode    = 1'($urandom_range(0, 1));
      n_count = n_items * 55 / 100;
      n_map   = n_items - n_count - 1;
      case ($urandom_range(0, 7))
         0: target = '0;
         1: target = '1;
         2: target = $urandom;
         3: target = $urandom_range(1, 4);
         default: target = $urandom_range(1, n_count);
      endcase
      write_csr(ADDR_SAMPLE_MODE, CSR_DATA_BITS'(mode));
      write_csr(ADDR_WHITE_COUNT, target);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
      base    = SAMPLE_BITS'($urandom);
      spread  = (mode && $urandom_range(0, 1)) ? 65535 : 255;
      // counts first, a finish, then maps; a little noise on both sides
      for (int k = 0; k < n_count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 3) send_item(FUNC_IGNORED, SAMPLE_BITS'($urandom));
         if (r < 6) send_item(FUNC_MAP, pick_sample(base, spread));
         else send_item(FUNC_COUNT, pick_sample(base, spread));
      end
      send_item(FUNC_FINISH, SAMPLE_BITS'($urandom));
      for (int k = 0; k < n_map; k++) begin
         r = $urandom_range(0, 99);
         if (r < 4) send_item(FUNC_IGNORED, SAMPLE_BITS'($urandom));
         if (r < 10) send_item(FUNC_COUNT, pick_sample(base, spread));
         else send_item(FUNC_MAP, pick_sample(base, spread));
      end
      random_sent += n_items;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      write_csr(ADDR_SAMPLE_MODE, CSR_DATA_BITS'(1));
      write_csr(ADDR_WHITE_COUNT, '0);
      // empty histogram, then maps with both levels at the top bin
      send_item(FUNC_FINISH, 16'h0000);
      send_item(FUNC_MAP, 16'h0000);
      send_item(FUNC_MAP, 16'hFFFF);
      send_item(FUNC_MAP, 16'h8000);
      // repeated hits on one bin, back-to-back when the random gap is zero
      send_item(FUNC_COUNT, 16'h0000);
      send_item(FUNC_COUNT, 16'hFFFF);
      send_item(FUNC_COUNT, 16'hFFFF);
      send_item(FUNC_COUNT, 16'h1000);
      send_item(FUNC_IGNORED, 16'hFFFF);
      send_item(FUNC_FINISH, 16'hFFFF);
      send_item(FUNC_MAP, 16'h0000);
      send_item(FUNC_MAP, 16'hFFFE);
      send_item(FUNC_MAP, 16'h8000);
      send_item(FUNC_MAP, 16'hFFFF);

      // counts taken in 16-bit mode, then scanned in 8-bit mode
      drain_results();
      write_csr(ADDR_WHITE_COUNT, CSR_DATA_BITS'(2));
      send_item(FUNC_COUNT, 16'h1234);
      send_item(FUNC_COUNT, 16'hFFFF);
      drain_results();
      write_csr(ADDR_SAMPLE_MODE, CSR_DATA_BITS'(0));
      send_item(FUNC_COUNT, 16'h0110);
      send_item(FUNC_COUNT, 16'h00FF);
      send_item(FUNC_FINISH, 16'h0000);
      send_item(FUNC_MAP, 16'hAB20);
      send_item(FUNC_MAP, 16'h0005);

      // white search runs out at bin 0, levels cross
      drain_results();
      write_csr(ADDR_SAMPLE_MODE, CSR_DATA_BITS'(1));
      write_csr(ADDR_WHITE_COUNT, '1);
      send_item(FUNC_COUNT, 16'd5);
      send_item(FUNC_COUNT, 16'd70);
      send_item(FUNC_FINISH, 16'h0000);
      send_item(FUNC_MAP, 16'd3);
      send_item(FUNC_MAP, 16'd0);

      while (random_sent < RANDOM_ITEMS) run_phase($urandom_range(220, 260));

      drain_results();
      if (fail_count == 0 && results_due == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/hsa_pkg.sv
src/hsa_ram.sv
src/hsa_div.sv
src/histogram_auto_stretch.sv
sim/histogram_auto_stretch_checker.sv
sim/histogram_auto_stretch_tb.sv
